// ----- hw/rtl/prcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Particle receptor collision step package
// Shared widths, payload types, register indexes, state encoding and the
// coordinate arithmetic helpers used by the collision datapath.
// ----------------------------------------------------------------------------
package prcs_pkg;

  localparam int COORD_W = 24;
  localparam int STEP_W  = 20;
  localparam int SLOT_W  = 9;
  localparam int SQ_W    = 48;
  localparam int SUM_W   = 50;
  localparam int CD_W    = 23;
  localparam int CNT_W   = 10;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 12;
  localparam int NUM_W   = 13;

  localparam int DEF_MAX_RECEPTORS = 512;
  localparam int DEF_NUM_CELLS     = 8;

  localparam logic [SQ_W-1:0]  RST_SPHERE_RADIUS_SQ    = 48'd429496729600;
  localparam logic [CD_W-1:0]  RST_CONTACT_DISTANCE    = 23'd13107;
  localparam logic [SQ_W-1:0]  RST_CONTACT_DISTANCE_SQ = 48'd171798692;
  localparam logic [CNT_W-1:0] RST_RECEPTOR_COUNT      = 10'd500;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [1:0] {
    REG_SPHERE_RADIUS_SQ,
    REG_CONTACT_DISTANCE,
    REG_CONTACT_DISTANCE_SQ,
    REG_RECEPTOR_COUNT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SQUARE,
    ST_SPHERE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                      mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [STEP_W-1:0]  step_x;
    logic signed [STEP_W-1:0]  step_y;
    logic signed [STEP_W-1:0]  step_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
    logic                      outside;
    logic                      hit;
    logic [SLOT_W-1:0]         hit_index;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord3_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] base;
    logic             found;
    logic [IDX_W-1:0] hit_idx;
  } scan_bundle_t;

  function automatic logic signed [COORD_W-1:0] sat_move(
      input logic signed [COORD_W-1:0] p,
      input logic signed [STEP_W-1:0]  s);
    logic [COORD_W:0] sum;
    sum = {p[COORD_W-1], p} + {{(COORD_W+1-STEP_W){s[STEP_W-1]}}, s};
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      return sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return sum[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] magnitude(input logic [COORD_W:0] v);
    logic [COORD_W:0] m;
    m = v[COORD_W] ? (~v + 1'b1) : v;
    return m[COORD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/prcs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/prcs_cell.sv -----
// ----------------------------------------------------------------------------
// Receptor cell
// Holds one lane of the receptor table and tests each row it receives against
// the particle, passing the first hit on to the next cell.
// ----------------------------------------------------------------------------
module prcs_cell
  import prcs_pkg::*;
#(
  parameter int LANE   = 0,
  parameter int LANE_W = 3,
  parameter int ROWS   = 64,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  coord3_t           particle,
  input  logic [CD_W-1:0]   contact_distance,
  input  logic [SQ_W-1:0]   contact_distance_sq,
  input  logic [NUM_W-1:0]  num_entries,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_row,
  input  coord3_t           wr_data,
  input  scan_bundle_t      bundle_in,
  output scan_bundle_t      bundle_out
);

  coord3_t                 receptor;
  scan_bundle_t            s1;
  scan_bundle_t            s2;
  scan_bundle_t            s3;
  logic                    take2;
  logic                    take3;
  logic [COORD_W-1:0]      ax;
  logic [COORD_W-1:0]      ay;
  logic [COORD_W-1:0]      az;
  logic [SQ_W-1:0]         sqx;
  logic [SQ_W-1:0]         sqy;
  logic [SQ_W-1:0]         sqz;
  logic [IDX_W-1:0]        k1;
  logic [IDX_W-1:0]        k3;
  logic                    in_range;
  logic                    in_box;
  logic [COORD_W:0]        dx;
  logic [COORD_W:0]        dy;
  logic [COORD_W:0]        dz;
  logic [COORD_W-1:0]      mx;
  logic [COORD_W-1:0]      my;
  logic [COORD_W-1:0]      mz;
  logic [SUM_W-1:0]        dist_sq;
  logic                    hit;

  prcs_ram #(
    .WIDTH($bits(coord3_t)),
    .DEPTH(ROWS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_row),
    .wr_data(wr_data),
    .rd_addr(bundle_in.base[LANE_W +: ROW_W]),
    .rd_data(receptor)
  );

  always_comb begin
    k1       = s1.base | IDX_W'(LANE);
    in_range = NUM_W'(k1) < num_entries;
    dx       = {particle.x[COORD_W-1], particle.x} - {receptor.x[COORD_W-1], receptor.x};
    dy       = {particle.y[COORD_W-1], particle.y} - {receptor.y[COORD_W-1], receptor.y};
    dz       = {particle.z[COORD_W-1], particle.z} - {receptor.z[COORD_W-1], receptor.z};
    mx       = magnitude(dx);
    my       = magnitude(dy);
    mz       = magnitude(dz);
    in_box   = (mx <= COORD_W'(contact_distance)) && (my <= COORD_W'(contact_distance))
               && (mz <= COORD_W'(contact_distance));
  end

  always_comb begin
    k3      = s3.base | IDX_W'(LANE);
    dist_sq = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
    hit     = take3 && (dist_sq < SUM_W'(contact_distance_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1         <= '0;
      s2         <= '0;
      s3         <= '0;
      bundle_out <= '0;
    end else begin
      s1 <= bundle_in;
      s2 <= s1;
      s3 <= s2;
      bundle_out.valid   <= s3.valid;
      bundle_out.base    <= s3.base;
      bundle_out.found   <= s3.found || hit;
      bundle_out.hit_idx <= (!s3.found && hit) ? k3 : s3.hit_idx;
    end
  end

  always_ff @(posedge clk) begin
    take2 <= in_range && in_box;
    ax    <= mx;
    ay    <= my;
    az    <= mz;
    take3 <= take2;
    sqx   <= ax * ax;
    sqy   <= ay * ay;
    sqz   <= az * az;
  end

endmodule

// ----- hw/rtl/particle_receptor_collision_step.sv -----
// ----------------------------------------------------------------------------
// Particle receptor collision step
// Moves a particle by a saturating step, checks it against the receiver
// sphere and scans a receptor table held in a chain of cells for the first
// receptor within contact distance.
// ----------------------------------------------------------------------------
// A load transaction gives no result.
// A step transaction that ends outside the sphere goes from ST_SPHERE
// straight to ST_DONE and gives its result without a scan; otherwise
// ROWS = ceil(MAX_RECEPTORS / NUM_CELLS) rows are first fed one per cycle
// into the cell chain. One step transaction is in work at a time.
// Reset restores the register defaults; the receptor table is not cleared.
module particle_receptor_collision_step
  import prcs_pkg::*;
#(
  parameter int MAX_RECEPTORS = DEF_MAX_RECEPTORS,
  parameter int NUM_CELLS     = DEF_NUM_CELLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LANE_W = $clog2(NUM_CELLS);
  localparam int ROWS   = (MAX_RECEPTORS + NUM_CELLS - 1) / NUM_CELLS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCNT_W = $clog2(ROWS + 1);

  state_t              state;
  state_t              state_next;
  logic [SQ_W-1:0]     sphere_radius_sq;
  logic [CD_W-1:0]     contact_distance;
  logic [SQ_W-1:0]     contact_distance_sq;
  logic [CNT_W-1:0]    receptor_count;
  logic [NUM_W-1:0]    num_entries;
  coord3_t             moved;
  coord3_t             wr_data;
  logic [SQ_W-1:0]     sqx;
  logic [SQ_W-1:0]     sqy;
  logic [SQ_W-1:0]     sqz;
  logic                outside;
  logic [RCNT_W-1:0]   row_issue;
  logic [RCNT_W-1:0]   ret_cnt;
  logic                have_hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                in_accept;
  logic                step_accept;
  logic                load_accept;
  logic                wr_sel;
  logic [IDX_W-1:0]    slot_ext;
  logic                scan_issue;
  logic                out_load;
  logic [NUM_CELLS-1:0] cell_we;
  scan_bundle_t        chain [NUM_CELLS+1];

  assign in_accept   = in_valid && !in_stall;
  assign step_accept = in_accept && (in_data.mode == MODE_STEP);
  assign load_accept = in_accept && (in_data.mode == MODE_LOAD);
  assign slot_ext    = IDX_W'(in_data.slot);
  assign wr_sel      = load_accept && (NUM_W'(in_data.slot) < NUM_W'(MAX_RECEPTORS));
  assign num_entries = (NUM_W'(receptor_count) > NUM_W'(MAX_RECEPTORS)) ?
                       NUM_W'(MAX_RECEPTORS) : NUM_W'(receptor_count);
  assign wr_data     = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius_sq    <= RST_SPHERE_RADIUS_SQ;
      contact_distance    <= RST_CONTACT_DISTANCE;
      contact_distance_sq <= RST_CONTACT_DISTANCE_SQ;
      receptor_count      <= RST_RECEPTOR_COUNT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPHERE_RADIUS_SQ:    sphere_radius_sq    <= cfg_data[SQ_W-1:0];
        REG_CONTACT_DISTANCE:    contact_distance    <= cfg_data[CD_W-1:0];
        REG_CONTACT_DISTANCE_SQ: contact_distance_sq <= cfg_data[SQ_W-1:0];
        REG_RECEPTOR_COUNT:      receptor_count      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (step_accept) state_next = ST_MOVE;
      ST_MOVE:   state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SPHERE;
      ST_SPHERE: state_next = outside ? ST_DONE : ST_SCAN;
      ST_SCAN:   if (row_issue == RCNT_W'(ROWS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  if (ret_cnt == RCNT_W'(ROWS)) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != ST_IDLE);
    scan_issue = (state == ST_SCAN);
    out_load   = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_accept) begin
      moved.x <= sat_move(in_data.pos_x, in_data.step_x);
      moved.y <= sat_move(in_data.pos_y, in_data.step_y);
      moved.z <= sat_move(in_data.pos_z, in_data.step_z);
    end
    sqx     <= magnitude({moved.x[COORD_W-1], moved.x}) * magnitude({moved.x[COORD_W-1], moved.x});
    sqy     <= magnitude({moved.y[COORD_W-1], moved.y}) * magnitude({moved.y[COORD_W-1], moved.y});
    sqz     <= magnitude({moved.z[COORD_W-1], moved.z}) * magnitude({moved.z[COORD_W-1], moved.z});
    outside <= (SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz)) > SUM_W'(sphere_radius_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_issue <= '0;
      ret_cnt   <= '0;
      have_hit  <= 1'b0;
      hit_idx   <= '0;
      chain[0]  <= '0;
    end else begin
      chain[0].valid   <= scan_issue;
      chain[0].base    <= IDX_W'({row_issue[ROW_W-1:0], {LANE_W{1'b0}}});
      chain[0].found   <= 1'b0;
      chain[0].hit_idx <= '0;
      if (step_accept) begin
        row_issue <= '0;
        ret_cnt   <= '0;
        have_hit  <= 1'b0;
        hit_idx   <= '0;
      end else begin
        if (scan_issue) begin
          row_issue <= row_issue + 1'b1;
        end
        if (chain[NUM_CELLS].valid) begin
          ret_cnt <= ret_cnt + 1'b1;
          if (chain[NUM_CELLS].found && !have_hit) begin
            have_hit <= 1'b1;
            hit_idx  <= chain[NUM_CELLS].hit_idx;
          end
        end
      end
    end
  end

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    assign cell_we[j] = wr_sel && (slot_ext[LANE_W-1:0] == LANE_W'(j));

    prcs_cell #(
      .LANE  (j),
      .LANE_W(LANE_W),
      .ROWS  (ROWS)
    ) u_cell (
      .clk                (clk),
      .rst                (rst),
      .particle           (moved),
      .contact_distance   (contact_distance),
      .contact_distance_sq(contact_distance_sq),
      .num_entries        (num_entries),
      .wr_en              (cell_we[j]),
      .wr_row             (slot_ext[LANE_W +: ROW_W]),
      .wr_data            (wr_data),
      .bundle_in          (chain[j]),
      .bundle_out         (chain[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.new_x     <= moved.x;
      out_data.new_y     <= moved.y;
      out_data.new_z     <= moved.z;
      out_data.outside   <= outside;
      out_data.hit       <= have_hit && !outside;
      out_data.hit_index <= (have_hit && !outside) ? hit_idx[SLOT_W-1:0] : '0;
    end
  end

  a_outside_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outside |-> !out_data.hit)
    else $error("Result flags both outside and hit.");

  a_no_hit_zero_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.hit_index == '0)
    else $error("Result without a hit carries a nonzero index.");

  a_return_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_CELLS].valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("Cell chain returned a row outside of a scan.");

  a_return_bound: assert property (@(posedge clk) disable iff (rst)
    ret_cnt <= RCNT_W'(ROWS))
    else $error("More rows returned than were issued.");

  a_done_scan_complete: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DONE) && !outside |-> ret_cnt == RCNT_W'(ROWS))
    else $error("Result formed before every row came back.");

endmodule
